### rtl/gbfp_pkg.sv
// Package of the GNSS binary frame parser: sync and message constants,
// parser phases, queue operation codes and the result kinds.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package gbfp_pkg;

  localparam logic [7:0] SYNC_FIRST = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [15:0] MAX_LEN_RESET = 16'd500;

  localparam logic [7:0] CLASS_NAV = 8'h01;
  localparam logic [7:0] CLASS_ESF = 8'h10;
  localparam logic [7:0] ID_ESF_STATUS = 8'h10;
  localparam logic [7:0] ID_ESF_MEAS = 8'h14;
  localparam logic [7:0] ID_NAV_STATUS = 8'h03;

  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [3:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B
  } phase_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_NOISE1,
    OP_NOISE2,
    OP_SYNC,
    OP_CLASS,
    OP_ID,
    OP_LEN_LO,
    OP_LEN_HI,
    OP_LEN_REJECT,
    OP_PAYLOAD,
    OP_CK_A,
    OP_CK_B
  } op_e;

  typedef enum logic [1:0] {
    RES_PAYLOAD = 2'd0,
    RES_GOOD = 2'd1,
    RES_MISMATCH = 2'd2,
    RES_REJECT = 2'd3
  } result_e;

  typedef enum logic [1:0] {
    MSG_OTHER = 2'd0,
    MSG_ESF_MEAS = 2'd1,
    MSG_ESF_STATUS = 2'd2,
    MSG_NAV_STATUS = 2'd3
  } msg_kind_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic [15:0] index;
  } op_t;

  typedef struct packed {
    logic [15:0] skipped_bytes;
    msg_kind_e   msg_kind;
    logic [15:0] payload_len;
    logic [7:0]  msg_id;
    logic [7:0]  msg_class;
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
  } result_t;

  function automatic msg_kind_e kind_of(input logic [7:0] cls, input logic [7:0] id);
    msg_kind_e k;
    k = MSG_OTHER;
    if (cls == CLASS_ESF && id == ID_ESF_MEAS) begin
      k = MSG_ESF_MEAS;
    end else if (cls == CLASS_ESF && id == ID_ESF_STATUS) begin
      k = MSG_ESF_STATUS;
    end else if (cls == CLASS_NAV && id == ID_NAV_STATUS) begin
      k = MSG_NAV_STATUS;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/gnss_binary_frame_parser.sv
// Top level of the GNSS binary frame parser: front part, operation queue and
// back part. Depends on gbfp_pkg, gbfp_front, gbfp_queue and gbfp_back.
//
//   channel   | direction | valid/ready               | payload
//   ----------+-----------+---------------------------+--------------------------
//   s_axis    | in        | s_axis_tvalid_i/tready_o  | tdata: rx_byte
//   m_axis    | out       | m_axis_tvalid_o/tready_i  | tdata: result fields,
//             |           |                           | tuser: result_kind
//   cfg       | in        | cfg_we_i                  | cfg_wdata_i: max_payload_len
//
// One byte is accepted per cycle while the queue is not full; its operation is
// queued and its result is then registered in the back part. The rate is set by
// the phase update in the front part and the sum update in the back part; the
// queue lets either side stall alone. Reset is asynchronous and active low and
// needs no clearing pass. A stalled output holds its transaction; input
// acceptance stops once the queue is full.
`default_nettype none

module gnss_binary_frame_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [15:0]                      cfg_wdata_i,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // rx_byte[7:0]
  input  wire logic [gbfp_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // data_byte[7:0], byte_index[23:8], msg_class[31:24], msg_id[39:32],
  // payload_len[55:40], msg_kind[57:56], skipped_bytes[73:58], zero[79:74]
  output logic [gbfp_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // result_kind[1:0]
  output logic [gbfp_pkg::OUT_USER_W-1:0]       m_axis_tuser_o
);

  gbfp_pkg::op_t     front_op;
  gbfp_pkg::op_t     back_op;
  gbfp_pkg::result_t res;
  gbfp_pkg::result_e res_kind;
  logic              in_accept;
  logic              q_full;
  logic              q_empty;
  logic              back_ready;

  assign s_axis_tready_o = !q_full;
  assign in_accept = s_axis_tvalid_i && !q_full;

  gbfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (in_accept),
    .rx_byte_i   (s_axis_tdata_i),
    .op_o        (front_op)
  );

  gbfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_accept),
    .push_op_i (front_op),
    .full_o    (q_full),
    .pop_i     (!q_empty && back_ready),
    .empty_o   (q_empty),
    .pop_op_o  (back_op)
  );

  gbfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!q_empty),
    .op_i        (back_op),
    .op_ready_o  (back_ready),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_kind_o  (res_kind),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {6'b000000, res};
  assign m_axis_tuser_o = res_kind;

endmodule

`default_nettype wire

### rtl/gbfp_front.sv
// Front part of the frame parser: tracks the frame phase per received byte
// and turns each byte into one operation for the back part. Uses gbfp_pkg.
`default_nettype none

module gbfp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    rx_byte_i,
  output gbfp_pkg::op_t      op_o
);

  gbfp_pkg::phase_e phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] max_len_q;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;

  assign len_full = {rx_byte_i, len_q[7:0]};
  assign cnt_inc = cnt_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    len_d = len_q;
    cnt_d = cnt_q;
    case (phase_q)
      gbfp_pkg::PH_HUNT1: begin
        if (rx_byte_i == gbfp_pkg::SYNC_FIRST) phase_d = gbfp_pkg::PH_HUNT2;
      end
      gbfp_pkg::PH_HUNT2: begin
        if (rx_byte_i == gbfp_pkg::SYNC_SECOND) begin
          phase_d = gbfp_pkg::PH_CLASS;
        end else if (rx_byte_i != gbfp_pkg::SYNC_FIRST) begin
          phase_d = gbfp_pkg::PH_HUNT1;
        end
      end
      gbfp_pkg::PH_CLASS: phase_d = gbfp_pkg::PH_ID;
      gbfp_pkg::PH_ID: phase_d = gbfp_pkg::PH_LEN_LO;
      gbfp_pkg::PH_LEN_LO: begin
        len_d = {8'h00, rx_byte_i};
        phase_d = gbfp_pkg::PH_LEN_HI;
      end
      gbfp_pkg::PH_LEN_HI: begin
        len_d = len_full;
        cnt_d = '0;
        if (len_full > max_len_q) begin
          phase_d = gbfp_pkg::PH_HUNT1;
        end else if (len_full == 16'd0) begin
          phase_d = gbfp_pkg::PH_CK_A;
        end else begin
          phase_d = gbfp_pkg::PH_PAYLOAD;
        end
      end
      gbfp_pkg::PH_PAYLOAD: begin
        cnt_d = cnt_inc;
        if (cnt_inc == len_q) phase_d = gbfp_pkg::PH_CK_A;
      end
      gbfp_pkg::PH_CK_A: phase_d = gbfp_pkg::PH_CK_B;
      gbfp_pkg::PH_CK_B: phase_d = gbfp_pkg::PH_HUNT1;
      default: phase_d = gbfp_pkg::PH_HUNT1;
    endcase
  end

  always_comb begin
    op_o.data = rx_byte_i;
    op_o.index = cnt_q;
    case (phase_q)
      gbfp_pkg::PH_HUNT1: begin
        op_o.op = (rx_byte_i == gbfp_pkg::SYNC_FIRST) ? gbfp_pkg::OP_NONE
                                                      : gbfp_pkg::OP_NOISE1;
      end
      gbfp_pkg::PH_HUNT2: begin
        if (rx_byte_i == gbfp_pkg::SYNC_SECOND) begin
          op_o.op = gbfp_pkg::OP_SYNC;
        end else if (rx_byte_i == gbfp_pkg::SYNC_FIRST) begin
          op_o.op = gbfp_pkg::OP_NOISE1;
        end else begin
          op_o.op = gbfp_pkg::OP_NOISE2;
        end
      end
      gbfp_pkg::PH_CLASS: op_o.op = gbfp_pkg::OP_CLASS;
      gbfp_pkg::PH_ID: op_o.op = gbfp_pkg::OP_ID;
      gbfp_pkg::PH_LEN_LO: op_o.op = gbfp_pkg::OP_LEN_LO;
      gbfp_pkg::PH_LEN_HI: begin
        op_o.op = (len_full > max_len_q) ? gbfp_pkg::OP_LEN_REJECT : gbfp_pkg::OP_LEN_HI;
      end
      gbfp_pkg::PH_PAYLOAD: op_o.op = gbfp_pkg::OP_PAYLOAD;
      gbfp_pkg::PH_CK_A: op_o.op = gbfp_pkg::OP_CK_A;
      gbfp_pkg::PH_CK_B: op_o.op = gbfp_pkg::OP_CK_B;
      default: op_o.op = gbfp_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gbfp_pkg::PH_HUNT1;
      len_q <= '0;
      cnt_q <= '0;
      max_len_q <= gbfp_pkg::MAX_LEN_RESET;
    end else begin
      if (accept_i) begin
        phase_q <= phase_d;
        len_q <= len_d;
        cnt_q <= cnt_d;
      end
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/gbfp_queue.sv
// Short operation queue between the front and back parts of the parser.
// Holds gbfp_pkg::op_t entries; depth set by the Depth parameter.
`default_nettype none

module gbfp_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  gbfp_pkg::op_t      push_op_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output gbfp_pkg::op_t      pop_op_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  gbfp_pkg::op_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign pop_op_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/gbfp_back.sv
// Back part of the frame parser: carries out queued operations, keeps the
// Fletcher sums, header fields and noise count, and holds the result register.
// Uses gbfp_pkg.
`default_nettype none

module gbfp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          op_valid_i,
  input  gbfp_pkg::op_t      op_i,
  output logic               op_ready_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output gbfp_pkg::result_e  res_kind_o,
  output gbfp_pkg::result_t  res_o
);

  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  rx_sum_a_q, rx_sum_a_d;
  logic [15:0] noise_q, noise_d;
  logic        out_valid_q, out_valid_d;
  gbfp_pkg::result_e kind_q, kind_d;
  gbfp_pkg::result_t res_q, res_d;
  logic [7:0]  add_a;
  logic        fire;
  logic        emit;

  assign op_ready_o = !out_valid_q || res_ready_i;
  assign fire = op_valid_i && op_ready_o;
  assign add_a = sum_a_q + op_i.data;

  always_comb begin
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    class_d = class_q;
    id_d = id_q;
    len_d = len_q;
    rx_sum_a_d = rx_sum_a_q;
    noise_d = noise_q;
    emit = 1'b0;
    kind_d = kind_q;
    res_d.data_byte = '0;
    res_d.byte_index = '0;
    res_d.msg_class = class_q;
    res_d.msg_id = id_q;
    res_d.payload_len = len_q;
    res_d.msg_kind = gbfp_pkg::kind_of(class_q, id_q);
    res_d.skipped_bytes = noise_q;
    case (op_i.op)
      gbfp_pkg::OP_NOISE1: begin
        if (noise_q != 16'hFFFF) noise_d = noise_q + 16'd1;
      end
      gbfp_pkg::OP_NOISE2: begin
        noise_d = (noise_q >= 16'hFFFE) ? 16'hFFFF : noise_q + 16'd2;
      end
      gbfp_pkg::OP_SYNC: begin
        sum_a_d = '0;
        sum_b_d = '0;
      end
      gbfp_pkg::OP_CLASS: begin
        class_d = op_i.data;
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
      end
      gbfp_pkg::OP_ID: begin
        id_d = op_i.data;
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
      end
      gbfp_pkg::OP_LEN_LO: begin
        len_d = {8'h00, op_i.data};
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
      end
      gbfp_pkg::OP_LEN_HI: begin
        len_d = {op_i.data, len_q[7:0]};
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
      end
      gbfp_pkg::OP_LEN_REJECT: begin
        len_d = {op_i.data, len_q[7:0]};
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
        emit = 1'b1;
        kind_d = gbfp_pkg::RES_REJECT;
        res_d.payload_len = {op_i.data, len_q[7:0]};
        noise_d = '0;
      end
      gbfp_pkg::OP_PAYLOAD: begin
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
        emit = 1'b1;
        kind_d = gbfp_pkg::RES_PAYLOAD;
        res_d.data_byte = op_i.data;
        res_d.byte_index = op_i.index;
      end
      gbfp_pkg::OP_CK_A: rx_sum_a_d = op_i.data;
      gbfp_pkg::OP_CK_B: begin
        emit = 1'b1;
        kind_d = (rx_sum_a_q == sum_a_q && op_i.data == sum_b_q) ? gbfp_pkg::RES_GOOD
                                                                 : gbfp_pkg::RES_MISMATCH;
        noise_d = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready_i) out_valid_d = 1'b0;
    if (fire && emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= '0;
      sum_b_q <= '0;
      class_q <= '0;
      id_q <= '0;
      len_q <= '0;
      rx_sum_a_q <= '0;
      noise_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        sum_a_q <= sum_a_d;
        sum_b_q <= sum_b_d;
        class_q <= class_d;
        id_q <= id_d;
        len_q <= len_d;
        rx_sum_a_q <= rx_sum_a_d;
        noise_q <= noise_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      kind_q <= kind_d;
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_kind_o = kind_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

### rtl/gbfp_checker.sv
// Port-level checker for the GNSS binary frame parser and its bind statement.
// Depends on gbfp_pkg and the ports of gnss_binary_frame_parser.
`default_nettype none

module gbfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [79:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("Stalled output transaction changed.");

  a_frame_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != gbfp_pkg::RES_PAYLOAD |->
      m_axis_tdata_o[23:0] == 24'd0)
    else $error("Frame end report carries payload byte or index.");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == gbfp_pkg::RES_PAYLOAD |->
      m_axis_tdata_o[23:8] < m_axis_tdata_o[55:40] && m_axis_tdata_o[57:56] ==
      gbfp_pkg::kind_of(m_axis_tdata_o[31:24], m_axis_tdata_o[39:32]))
    else $error("Payload transaction has bad index or message kind.");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("Output transaction offered during reset.");

endmodule

bind gnss_binary_frame_parser gbfp_checker u_gbfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
